// ----- hdl/imm_pkg.sv -----
// Package for the integer matrix multiplier: command and result payload types,
// operation and register codes, sequencer state and the element index helper.
// No dependencies.
`default_nettype none

package imm_pkg;

  // Default sizes; the top level hands these down as parameters.
  localparam int MaxDim   = 8;
  localparam int ElemBits = 16;

  // Fixed widths of the channel fields.
  localparam int IdxBits   = 3;
  localparam int ValueBits = 16;
  localparam int ResBits   = 35;
  localparam int DimBits   = 4;
  localparam int CfgIdxBits = 2;

  // Operation codes of a command.
  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MULT   = 2'd2,
    OP_NONE   = 2'd3
  } imm_op_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxBits-1:0] {
    CFG_ROWS_A    = 2'd0,
    CFG_INNER_DIM = 2'd1,
    CFG_COLS_B    = 2'd2,
    CFG_UNUSED    = 2'd3
  } imm_cfg_e;

  // Sequencer states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } imm_state_e;

  // One command transfer.
  typedef struct packed {
    imm_op_e                      operation;
    logic [IdxBits-1:0]           row;
    logic [IdxBits-1:0]           col;
    logic signed [ValueBits-1:0]  value;
  } imm_cmd_t;

  // One result transfer.
  typedef struct packed {
    logic signed [ResBits-1:0] product_value;
    logic [IdxBits-1:0]        out_row;
    logic [IdxBits-1:0]        out_col;
    logic                      last;
  } imm_res_t;

  // Tag that travels with each multiply-accumulate step.
  typedef struct packed {
    logic               valid;
    logic               first;
    logic               lastk;
    logic [IdxBits-1:0] row;
    logic [IdxBits-1:0] col;
    logic               last;
  } imm_tag_t;

  // Linear element index row*dim+col; dim is a constant at every call site.
  function automatic logic [6:0] imm_index(input logic [IdxBits-1:0] row,
                                            input logic [IdxBits-1:0] col,
                                            input int dim);
    return 7'(7'(row) * 7'(dim) + 7'(col));
  endfunction

  // Effective dimension: zero acts as one, values above the maximum clamp.
  function automatic logic [DimBits-1:0] imm_eff_dim(input logic [DimBits-1:0] reg_val,
                                                      input int dim);
    logic [DimBits-1:0] res;
    res = reg_val;
    if (reg_val == '0) begin
      res = DimBits'(1);
    end else if (reg_val > DimBits'(dim)) begin
      res = DimBits'(dim);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/imm_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module imm_ram #(
  parameter int Width = 16,
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [Width-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ----- hdl/imm_seq.sv -----
// Sequencer: walks result rows, result columns and inner terms, one
// multiply-accumulate step per cycle. Depends on imm_pkg.
`default_nettype none

module imm_seq
  import imm_pkg::*;
#(
  parameter int MAX_DIM = MaxDim,
  parameter int AddrW   = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               go_i,
  input  wire logic [DimBits-1:0] nr_i,
  input  wire logic [DimBits-1:0] nk_i,
  input  wire logic [DimBits-1:0] nc_i,
  output logic                    run_o,
  output logic      [AddrW-1:0]   a_addr_o,
  output logic      [AddrW-1:0]   b_addr_o,
  output imm_tag_t                tag_o
);

  imm_state_e          state_q, state_d;
  logic [IdxBits-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic                last_i, last_j, last_k;

  // State and loop counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      k_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      k_q     <= k_d;
    end
  end

  assign last_i = (DimBits'(i_q) + DimBits'(1)) == nr_i;
  assign last_j = (DimBits'(j_q) + DimBits'(1)) == nc_i;
  assign last_k = (DimBits'(k_q) + DimBits'(1)) == nk_i;

  // Next state, counter stepping and the step issued this cycle.
  always_comb begin
    state_d   = state_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    tag_o     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (go_i) begin
          state_d = ST_RUN;
          i_d     = '0;
          j_d     = '0;
          k_d     = '0;
        end
      end
      ST_RUN: begin
        tag_o.valid = 1'b1;
        tag_o.first = (k_q == '0);
        tag_o.lastk = last_k;
        tag_o.row   = i_q;
        tag_o.col   = j_q;
        tag_o.last  = last_i && last_j;
        if (!last_k) begin
          k_d = k_q + IdxBits'(1);
        end else begin
          k_d = '0;
          if (!last_j) begin
            j_d = j_q + IdxBits'(1);
          end else begin
            j_d = '0;
            if (!last_i) begin
              i_d = i_q + IdxBits'(1);
            end else begin
              i_d     = '0;
              state_d = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign run_o    = (state_q == ST_RUN);
  assign a_addr_o = AddrW'(imm_index(i_q, k_q, MAX_DIM));
  assign b_addr_o = AddrW'(imm_index(k_q, j_q, MAX_DIM));

endmodule

`default_nettype wire

// ----- hdl/imm_mac.sv -----
// Shared multiply-accumulate unit: registered product, then a 35-bit
// accumulator that restarts on each new dot product. Depends on imm_pkg.
`default_nettype none

module imm_mac
  import imm_pkg::*;
#(
  parameter int ELEM_BITS = ElemBits
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire imm_tag_t             tag_i,
  input  wire logic [ELEM_BITS-1:0] a_i,
  input  wire logic [ELEM_BITS-1:0] b_i,
  output logic                      busy_o,
  output logic                      res_valid_o,
  output imm_res_t                  res_o
);

  localparam int ProdW = 2 * ELEM_BITS;
  localparam int ExtW  = (ProdW > ResBits) ? ProdW : ResBits;

  imm_tag_t                  tag1_q, tag2_q;
  logic signed [ProdW-1:0]   prod_q;
  logic        [ExtW-1:0]    prod_ext;
  logic        [ResBits-1:0] acc_q, sum;
  logic                      res_valid_q;
  imm_res_t                  res_q;

  // Tags follow the RAM read stage and the product stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q      <= '0;
      tag2_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      tag1_q      <= tag_i;
      tag2_q      <= tag1_q;
      res_valid_q <= tag2_q.valid && tag2_q.lastk;
    end
  end

  // Product of the two stored elements.
  always_ff @(posedge clk_i) begin
    prod_q <= signed'(a_i) * signed'(b_i);
  end

  assign prod_ext = ExtW'(prod_q);
  assign sum      = (tag2_q.first ? '0 : acc_q) + prod_ext[ResBits-1:0];

  // Accumulate and capture a finished dot product.
  always_ff @(posedge clk_i) begin
    if (tag2_q.valid) begin
      acc_q <= sum;
      if (tag2_q.lastk) begin
        res_q.product_value <= sum;
        res_q.out_row       <= tag2_q.row;
        res_q.out_col       <= tag2_q.col;
        res_q.last          <= tag2_q.last;
      end
    end
  end

  assign busy_o      = tag1_q.valid || tag2_q.valid;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- hdl/integer_matrix_multiply.sv -----
// Top level of the integer matrix multiplier: command decode, configuration
// registers, element stores. Depends on imm_pkg, imm_ram, imm_seq, imm_mac.
//
// Usage:
//   A command transfers at a rising edge with start high and busy low.
//   Load A / load B commands write one element in that same cycle and never
//   raise busy; a load whose row or col is not below MAX_DIM is dropped.
//   A multiply command raises busy at the next cycle and the block then
//   issues one multiply-accumulate step per cycle through a single shared
//   multiplier and accumulator.
//   Results appear in row-major order on result_o, each for exactly one
//   cycle with result_valid_o high, one per dot product of inner_dim terms.
//   Busy drops in the cycle the final result (last set) is shown.
//   The receiver cannot stall: each result must be taken as shown.
//   Configuration writes (cfg_we_i, cfg_idx_i, cfg_data_i) take effect at
//   once and belong to idle periods. Reset sets all three dimensions to the
//   maximum; the element stores are not cleared and must be loaded first.
`default_nettype none

module integer_matrix_multiply
  import imm_pkg::*;
#(
  parameter int MAX_DIM   = MaxDim,
  parameter int ELEM_BITS = ElemBits
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  start,
  output logic                       busy,
  input  wire imm_cmd_t              cmd_i,
  input  wire logic                  cfg_we_i,
  input  wire logic [CfgIdxBits-1:0] cfg_idx_i,
  input  wire logic [DimBits-1:0]    cfg_data_i,
  output logic                       result_valid_o,
  output imm_res_t                   result_o
);

  localparam int Depth = MAX_DIM * MAX_DIM;
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int VExtW = (ELEM_BITS > ValueBits) ? ELEM_BITS : ValueBits;

  logic [DimBits-1:0]   rows_a_q, inner_dim_q, cols_b_q;
  logic [DimBits-1:0]   nr, nk, nc;
  logic                 accept, in_range, go, we_a, we_b, run, mac_busy;
  logic [AddrW-1:0]     waddr, a_raddr, b_raddr;
  logic [VExtW-1:0]     value_ext;
  logic [ELEM_BITS-1:0] elem, a_rdata, b_rdata;
  imm_tag_t             tag;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DimBits'(MAX_DIM);
      inner_dim_q <= DimBits'(MAX_DIM);
      cols_b_q    <= DimBits'(MAX_DIM);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ROWS_A:    rows_a_q    <= cfg_data_i;
        CFG_INNER_DIM: inner_dim_q <= cfg_data_i;
        CFG_COLS_B:    cols_b_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign nr = imm_eff_dim(rows_a_q, MAX_DIM);
  assign nk = imm_eff_dim(inner_dim_q, MAX_DIM);
  assign nc = imm_eff_dim(cols_b_q, MAX_DIM);

  // Command decode.
  assign accept   = start && !busy;
  assign in_range = (DimBits'(cmd_i.row) < DimBits'(MAX_DIM)) &&
                    (DimBits'(cmd_i.col) < DimBits'(MAX_DIM));
  assign we_a     = accept && in_range && (cmd_i.operation == OP_LOAD_A);
  assign we_b     = accept && in_range && (cmd_i.operation == OP_LOAD_B);
  assign go       = accept && (cmd_i.operation == OP_MULT);
  assign waddr    = AddrW'(imm_index(cmd_i.row, cmd_i.col, MAX_DIM));

  // Element value: low ELEM_BITS bits of the sign-extended input.
  assign value_ext = VExtW'(cmd_i.value);
  assign elem      = value_ext[ELEM_BITS-1:0];

  imm_ram #(.Width(ELEM_BITS), .Depth(Depth), .AddrW(AddrW)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (elem),
    .raddr_i (a_raddr),
    .rdata_o (a_rdata)
  );

  imm_ram #(.Width(ELEM_BITS), .Depth(Depth), .AddrW(AddrW)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (elem),
    .raddr_i (b_raddr),
    .rdata_o (b_rdata)
  );

  imm_seq #(.MAX_DIM(MAX_DIM), .AddrW(AddrW)) u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .go_i     (go),
    .nr_i     (nr),
    .nk_i     (nk),
    .nc_i     (nc),
    .run_o    (run),
    .a_addr_o (a_raddr),
    .b_addr_o (b_raddr),
    .tag_o    (tag)
  );

  imm_mac #(.ELEM_BITS(ELEM_BITS)) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tag_i       (tag),
    .a_i         (a_rdata),
    .b_i         (b_rdata),
    .busy_o      (mac_busy),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

  assign busy = run || mac_busy;

`ifndef NO_ASSERTIONS
  // A result only follows a cycle in which the block was at work.
  a_result_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result shown without preceding work");

  // The final result of a multiply leaves the block idle.
  a_last_frees_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.last) |-> !busy)
    else $error("block still busy after final result");

  // A multiply command occupies the block from the next cycle.
  a_mult_sets_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.operation == OP_MULT)) |=> busy)
    else $error("multiply transfer did not start work");

  // Loads and unused commands never occupy the block.
  a_load_stays_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && (cmd_i.operation != OP_MULT)) |=> !busy)
    else $error("non-multiply transfer made the block busy");
`endif

endmodule

`default_nettype wire
